// ----- hw/rtl/planar_frame_transform_assert.svh -----
// Assertion macros used by the planar frame transform top level.
`ifndef PLANAR_FRAME_TRANSFORM_ASSERT_SVH
`define PLANAR_FRAME_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PFT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pft_pkg.sv -----
// Shared types, constants and the arctangent table of the planar frame transform.
package pft_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int POS_WIDTH_DEF     = 32;
    localparam int MAX_STAGES        = 32;

    // field widths
    localparam int POS_W  = 32;
    localparam int HEAD_W = 24;

    // datapath widths
    localparam int OPND_W      = 33;   // position operand, holds a difference
    localparam int XY_W        = 34;   // CORDIC x and y, Q1.30 plus headroom
    localparam int Z_W         = 33;   // CORDIC residual angle, Q.30
    localparam int RED_W       = 35;   // angle remainder path
    localparam int ZSHIFT      = 14;   // Q.16 to Q.30
    localparam int ROUND_SHIFT = 30;

    localparam logic [RED_W-1:0]        TURN_U      = 35'd6746518852;
    localparam logic signed [RED_W-1:0] TURN_Q30    = 35'sd6746518852;
    localparam logic signed [RED_W-1:0] HALF_Q30    = 35'sd3373259426;
    localparam logic signed [RED_W-1:0] QUARTER_Q30 = 35'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;

    // whole turns in a Q.16 heading: (abs * TURN_RECIP) >> RECIP_SHIFT, low by at most one
    localparam logic [13:0] TURN_RECIP   = 14'd10430;
    localparam int          RECIP_SHIFT  = 32;
    localparam int          Q_W          = 6;

    typedef struct packed {
        logic                     action;
        logic signed [OPND_W-1:0] opa;
        logic signed [OPND_W-1:0] opb;
        logic signed [POS_W-1:0]  offx;
        logic signed [POS_W-1:0]  offy;
        logic signed [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  curvature;
        logic signed [POS_W-1:0]  station;
    } side_t;

    typedef struct packed {
        side_t                  side;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } rot_t;

    function automatic logic [Z_W-1:0] atan_q30(input int idx);
        logic [Z_W-1:0] v;
        unique case (idx)
            0:  v = 33'd843314856;
            1:  v = 33'd497837829;
            2:  v = 33'd263043836;
            3:  v = 33'd133525158;
            4:  v = 33'd67021686;
            5:  v = 33'd33543515;
            6:  v = 33'd16775850;
            7:  v = 33'd8388437;
            8:  v = 33'd4194282;
            9:  v = 33'd2097149;
            10: v = 33'd1048575;
            11: v = 33'd524287;
            12: v = 33'd262143;
            13: v = 33'd131071;
            14: v = 33'd65535;
            15: v = 33'd32767;
            16: v = 33'd16383;
            17: v = 33'd8191;
            18: v = 33'd4095;
            19: v = 33'd2047;
            20: v = 33'd1023;
            21: v = 33'd511;
            22: v = 33'd255;
            23: v = 33'd127;
            24: v = 33'd63;
            25: v = 33'd31;
            26: v = 33'd15;
            27: v = 33'd7;
            28: v = 33'd3;
            29: v = 33'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/pft_reduce.sv -----
// Front end: operand setup, heading result, and angle reduction into the CORDIC range.
module pft_reduce import pft_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic signed [POS_W-1:0]  ref_x,
    input  logic signed [POS_W-1:0]  ref_y,
    input  logic signed [HEAD_W-1:0] ref_heading,
    input  logic signed [POS_W-1:0]  tgt_x,
    input  logic signed [POS_W-1:0]  tgt_y,
    input  logic signed [HEAD_W-1:0] tgt_heading,
    input  logic signed [POS_W-1:0]  tgt_curvature,
    input  logic signed [POS_W-1:0]  tgt_station,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rot_t                     out_data
);

    localparam int HS_W  = HEAD_W + 1;
    localparam int QP_W  = RECIP_SHIFT + Q_W;
    localparam int AZ_W  = HEAD_W + ZSHIFT;
    localparam int RP_W  = Q_W + RED_W;
    localparam logic signed [HS_W-1:0] HEAD_MAX = HS_W'((1 << (HEAD_W - 1)) - 1);
    localparam logic signed [HS_W-1:0] HEAD_MIN = -HEAD_MAX - HS_W'(1);

    typedef struct packed {
        side_t             side;
        logic              neg;
        logic [HEAD_W-1:0] abs_rh;
        logic [Q_W-1:0]    quo;
    } s0_t;

    typedef struct packed {
        side_t            side;
        logic             neg;
        logic [RED_W-1:0] rem;
    } s1_t;

    typedef struct packed {
        side_t                   side;
        logic signed [RED_W-1:0] z;
    } s2_t;

    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s0_valid_next, s1_valid_next, s2_valid_next, s3_valid_next;
    logic s0_ready, s1_ready, s2_ready, s3_ready;
    s0_t  s0_reg, s0_next;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    rot_t s3_reg, s3_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    assign s0_valid_next = s0_ready ? in_valid     : s0_valid_reg;
    assign s1_valid_next = s1_ready ? s0_valid_reg : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    // operands, heading result and whole-turn estimate
    always_comb begin
        logic [QP_W-1:0]          qprod;
        logic signed [OPND_W-1:0] dx;
        logic signed [OPND_W-1:0] dy;
        logic signed [HS_W-1:0]   hsum;
        s0_next.neg    = ref_heading[HEAD_W-1];
        s0_next.abs_rh = ref_heading[HEAD_W-1] ? HEAD_W'(-ref_heading) : HEAD_W'(ref_heading);
        qprod          = QP_W'(s0_next.abs_rh) * QP_W'(TURN_RECIP);
        s0_next.quo    = qprod[RECIP_SHIFT +: Q_W];
        dx = OPND_W'(tgt_x) - OPND_W'(ref_x);
        dy = OPND_W'(tgt_y) - OPND_W'(ref_y);
        hsum = action ? HS_W'(tgt_heading) - HS_W'(ref_heading)
                      : HS_W'(ref_heading) + HS_W'(tgt_heading);
        s0_next.side.action = action;
        s0_next.side.opa    = action ? dx : OPND_W'(tgt_x);
        s0_next.side.opb    = action ? dy : OPND_W'(tgt_y);
        s0_next.side.offx   = action ? '0 : ref_x;
        s0_next.side.offy   = action ? '0 : ref_y;
        priority if (hsum > HEAD_MAX) begin
            s0_next.side.heading = HEAD_MAX[HEAD_W-1:0];
        end
        else if (hsum < HEAD_MIN) begin
            s0_next.side.heading = HEAD_MIN[HEAD_W-1:0];
        end
        else begin
            s0_next.side.heading = hsum[HEAD_W-1:0];
        end
        s0_next.side.curvature = tgt_curvature;
        s0_next.side.station   = action ? '0 : tgt_station;
    end

    // remainder after the estimated whole turns
    always_comb begin
        logic [AZ_W-1:0] abs_z;
        logic [RP_W-1:0] qt;
        logic [RP_W-1:0] rem_full;
        abs_z        = {s0_reg.abs_rh, ZSHIFT'(0)};
        qt           = RP_W'(s0_reg.quo) * RP_W'(TURN_U);
        rem_full     = RP_W'(abs_z) - qt;
        s1_next.side = s0_reg.side;
        s1_next.neg  = s0_reg.neg;
        s1_next.rem  = rem_full[RED_W-1:0];
    end

    // correct the estimate by one turn, restore the sign
    always_comb begin
        logic [RED_W-1:0] r;
        r = (s1_reg.rem >= TURN_U) ? s1_reg.rem - TURN_U : s1_reg.rem;
        s2_next.side = s1_reg.side;
        s2_next.z    = s1_reg.neg ? -$signed(r) : $signed(r);
    end

    // wrap into one half turn each way, then fold into a quarter turn
    always_comb begin
        logic signed [RED_W-1:0] zw;
        logic signed [RED_W-1:0] zf;
        logic                    flip;
        priority if (s2_reg.z > HALF_Q30) begin
            zw = s2_reg.z - TURN_Q30;
        end
        else if (s2_reg.z < -HALF_Q30) begin
            zw = s2_reg.z + TURN_Q30;
        end
        else begin
            zw = s2_reg.z;
        end
        priority if (zw > QUARTER_Q30) begin
            zf   = zw - HALF_Q30;
            flip = 1'b1;
        end
        else if (zw < -QUARTER_Q30) begin
            zf   = zw + HALF_Q30;
            flip = 1'b1;
        end
        else begin
            zf   = zw;
            flip = 1'b0;
        end
        s3_next.side = s2_reg.side;
        s3_next.x    = GAIN_Q30;
        s3_next.y    = '0;
        s3_next.z    = zf[Z_W-1:0];
        s3_next.flip = flip;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (s0_ready) begin
            s0_reg <= s0_next;
        end
        if (s1_ready) begin
            s1_reg <= s1_next;
        end
        if (s2_ready) begin
            s2_reg <= s2_next;
        end
        if (s3_ready) begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

endmodule

// ----- hw/rtl/pft_cordic_cell.sv -----
// One CORDIC rotation cell: a fixed shift and arctangent, one register stage.
module pft_cordic_cell import pft_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rot_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rot_t out_data
);

    localparam logic signed [Z_W-1:0] ATAN = $signed(atan_q30(STAGE));

    logic valid_reg, valid_next;
    rot_t data_reg, data_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // zero residual rotates the positive way
    always_comb begin
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        dx        = in_data.y >>> STAGE;
        dy        = in_data.x >>> STAGE;
        data_next = in_data;
        if (!in_data.z[Z_W-1]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end
        else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/pft_rotate.sv -----
// Back end: position times cosine and sine, rounding, sums and saturation.
module pft_rotate import pft_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  rot_t                     in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [POS_W-1:0]  out_x,
    output logic signed [POS_W-1:0]  out_y,
    output logic signed [HEAD_W-1:0] out_heading,
    output logic signed [POS_W-1:0]  out_curvature,
    output logic signed [POS_W-1:0]  out_station
);

    localparam int AM_W    = OPND_W;
    localparam int CM_W    = XY_W - 1;
    localparam int LO_BITS = 16;
    localparam int HI_W    = AM_W - LO_BITS + CM_W;
    localparam int LO_W    = LO_BITS + CM_W;
    localparam int PP_W    = HI_W + LO_BITS + 1;
    localparam int PR_W    = PP_W - ROUND_SHIFT + 1;
    localparam int SUM_W   = (POS_WIDTH + 1 > PR_W + 2) ? POS_WIDTH + 1 : PR_W + 2;
    localparam logic [LO_W-1:0] ROUND_HALF = LO_W'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

    // product slots
    localparam int P_AC = 0;
    localparam int P_BS = 1;
    localparam int P_AS = 2;
    localparam int P_BC = 3;

    typedef struct packed {
        side_t           side;
        logic [AM_W-1:0] amag;
        logic [AM_W-1:0] bmag;
        logic [CM_W-1:0] cmag;
        logic [CM_W-1:0] smag;
        logic [3:0]      neg;
    } mag_t;

    typedef struct packed {
        side_t                 side;
        logic [3:0][HI_W-1:0] hi;
        logic [3:0][LO_W-1:0] lo;
        logic [3:0]           neg;
    } pp_t;

    typedef struct packed {
        side_t                 side;
        logic [3:0][PR_W-1:0] p;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sx;
        logic signed [SUM_W-1:0]  sy;
        logic signed [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  curvature;
        logic signed [POS_W-1:0]  station;
    } sum_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  curvature;
        logic signed [POS_W-1:0]  station;
    } res_t;

    logic  r0_valid_reg, r1_valid_reg, r2_valid_reg, r3_valid_reg, r4_valid_reg;
    logic  r0_valid_next, r1_valid_next, r2_valid_next, r3_valid_next, r4_valid_next;
    logic  r0_ready, r1_ready, r2_ready, r3_ready, r4_ready;
    mag_t  r0_reg, r0_next;
    pp_t   r1_reg, r1_next;
    prod_t r2_reg, r2_next;
    sum_t  r3_reg, r3_next;
    res_t  r4_reg, r4_next;

    assign r4_ready = !r4_valid_reg || out_ready;
    assign r3_ready = !r3_valid_reg || r4_ready;
    assign r2_ready = !r2_valid_reg || r3_ready;
    assign r1_ready = !r1_valid_reg || r2_ready;
    assign r0_ready = !r0_valid_reg || r1_ready;
    assign in_ready = r0_ready;

    assign r0_valid_next = r0_ready ? in_valid     : r0_valid_reg;
    assign r1_valid_next = r1_ready ? r0_valid_reg : r1_valid_reg;
    assign r2_valid_next = r2_ready ? r1_valid_reg : r2_valid_reg;
    assign r3_valid_next = r3_ready ? r2_valid_reg : r3_valid_reg;
    assign r4_valid_next = r4_ready ? r3_valid_reg : r4_valid_reg;

    // sign and magnitude of operands; a fold negates cosine and sine
    always_comb begin
        logic sa, sb, sc, ss;
        sa = in_data.side.opa[OPND_W-1];
        sb = in_data.side.opb[OPND_W-1];
        sc = in_data.x[XY_W-1] ^ in_data.flip;
        ss = in_data.y[XY_W-1] ^ in_data.flip;
        r0_next.side = in_data.side;
        r0_next.amag = sa ? AM_W'(-in_data.side.opa) : AM_W'(in_data.side.opa);
        r0_next.bmag = sb ? AM_W'(-in_data.side.opb) : AM_W'(in_data.side.opb);
        r0_next.cmag = in_data.x[XY_W-1] ? CM_W'(-in_data.x) : CM_W'(in_data.x);
        r0_next.smag = in_data.y[XY_W-1] ? CM_W'(-in_data.y) : CM_W'(in_data.y);
        r0_next.neg[P_AC] = sa ^ sc;
        r0_next.neg[P_BS] = sb ^ ss;
        r0_next.neg[P_AS] = sa ^ ss;
        r0_next.neg[P_BC] = sb ^ sc;
    end

    // split each product into high and low partial products, rounding folded in low
    always_comb begin
        logic [AM_W-1:0] aop;
        logic [CM_W-1:0] cop;
        r1_next.side = r0_reg.side;
        r1_next.neg  = r0_reg.neg;
        for (int k = 0; k < 4; k++) begin
            aop = (k == P_AC || k == P_AS) ? r0_reg.amag : r0_reg.bmag;
            cop = (k == P_AC || k == P_BC) ? r0_reg.cmag : r0_reg.smag;
            r1_next.hi[k] = HI_W'(aop[AM_W-1:LO_BITS]) * HI_W'(cop);
            r1_next.lo[k] = LO_W'(aop[LO_BITS-1:0]) * LO_W'(cop) + ROUND_HALF;
        end
    end

    // join partial products, drop fraction, apply sign
    always_comb begin
        logic [PP_W-1:0]   full;
        logic [PR_W-2:0]   mag;
        r2_next.side = r1_reg.side;
        for (int k = 0; k < 4; k++) begin
            full = (PP_W'(r1_reg.hi[k]) << LO_BITS) + PP_W'(r1_reg.lo[k]);
            mag  = full[PP_W-1:ROUND_SHIFT];
            r2_next.p[k] = r1_reg.neg[k] ? -{1'b0, mag} : {1'b0, mag};
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] pac, pbs, pas, pbc;
        pac = SUM_W'($signed(r2_reg.p[P_AC]));
        pbs = SUM_W'($signed(r2_reg.p[P_BS]));
        pas = SUM_W'($signed(r2_reg.p[P_AS]));
        pbc = SUM_W'($signed(r2_reg.p[P_BC]));
        r3_next.sx = pac + (r2_reg.side.action ? pbs : -pbs) + SUM_W'(r2_reg.side.offx);
        r3_next.sy = pbc + (r2_reg.side.action ? -pas : pas) + SUM_W'(r2_reg.side.offy);
        r3_next.heading   = r2_reg.side.heading;
        r3_next.curvature = r2_reg.side.curvature;
        r3_next.station   = r2_reg.side.station;
    end

    always_comb begin
        logic signed [SUM_W-1:0] cx, cy;
        priority if (r3_reg.sx > POS_MAX) begin
            cx = POS_MAX;
        end
        else if (r3_reg.sx < POS_MIN) begin
            cx = POS_MIN;
        end
        else begin
            cx = r3_reg.sx;
        end
        priority if (r3_reg.sy > POS_MAX) begin
            cy = POS_MAX;
        end
        else if (r3_reg.sy < POS_MIN) begin
            cy = POS_MIN;
        end
        else begin
            cy = r3_reg.sy;
        end
        r4_next.x         = cx[POS_W-1:0];
        r4_next.y         = cy[POS_W-1:0];
        r4_next.heading   = r3_reg.heading;
        r4_next.curvature = r3_reg.curvature;
        r4_next.station   = r3_reg.station;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            r0_valid_reg <= 1'b0;
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
        end
        else begin
            r0_valid_reg <= r0_valid_next;
            r1_valid_reg <= r1_valid_next;
            r2_valid_reg <= r2_valid_next;
            r3_valid_reg <= r3_valid_next;
            r4_valid_reg <= r4_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (r0_ready) begin
            r0_reg <= r0_next;
        end
        if (r1_ready) begin
            r1_reg <= r1_next;
        end
        if (r2_ready) begin
            r2_reg <= r2_next;
        end
        if (r3_ready) begin
            r3_reg <= r3_next;
        end
        if (r4_ready) begin
            r4_reg <= r4_next;
        end
    end

    assign out_valid     = r4_valid_reg;
    assign out_x         = r4_reg.x;
    assign out_y         = r4_reg.y;
    assign out_heading   = r4_reg.heading;
    assign out_curvature = r4_reg.curvature;
    assign out_station   = r4_reg.station;

endmodule

// ----- hw/rtl/planar_frame_transform.sv -----
// Top level of the planar frame transform: front end, CORDIC cell row, back end.
//
// Input channel: in_valid / in_stall with one pose pair per item (action, reference
// pose, target pose, curvature, station). Output channel: out_valid / out_stall with
// the transformed pose, curvature and station, one result item per input item.
// action 0 maps the target from the reference frame to the global frame, action 1
// maps it from the global frame into the reference frame and clears the station.
// The pipeline has four front-end stages, one CORDIC cell per CORDIC stage and
// five back-end stages (magnitudes, partial products, rounding, sums, saturation).
// Throughput is one item per cycle while the receiver does not stall; every
// stage is a register with its own valid bit, so items enter back to back.
// When the receiver stalls, the result holds at the outputs and items keep moving
// into empty stages behind it; in_stall rises only once every stage is occupied.
// Reset clears all valid bits; the pipeline is empty and ready on the first cycle
// after reset. There is no configuration and no state carried between items.
`include "planar_frame_transform_assert.svh"

module planar_frame_transform import pft_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     action,
    input  logic signed [POS_W-1:0]  ref_x,
    input  logic signed [POS_W-1:0]  ref_y,
    input  logic signed [HEAD_W-1:0] ref_heading,
    input  logic signed [POS_W-1:0]  tgt_x,
    input  logic signed [POS_W-1:0]  tgt_y,
    input  logic signed [HEAD_W-1:0] tgt_heading,
    input  logic signed [POS_W-1:0]  tgt_curvature,
    input  logic signed [POS_W-1:0]  tgt_station,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [POS_W-1:0]  out_x,
    output logic signed [POS_W-1:0]  out_y,
    output logic signed [HEAD_W-1:0] out_heading,
    output logic signed [POS_W-1:0]  out_curvature,
    output logic signed [POS_W-1:0]  out_station
);

    localparam int N_CELLS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    logic [N_CELLS:0] chain_valid;
    logic [N_CELLS:0] chain_ready;
    rot_t             chain_data [N_CELLS+1];
    logic             in_ready;

    assign in_stall = !in_ready;

    pft_reduce u_reduce (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .ref_x         (ref_x),
        .ref_y         (ref_y),
        .ref_heading   (ref_heading),
        .tgt_x         (tgt_x),
        .tgt_y         (tgt_y),
        .tgt_heading   (tgt_heading),
        .tgt_curvature (tgt_curvature),
        .tgt_station   (tgt_station),
        .out_valid     (chain_valid[0]),
        .out_ready     (chain_ready[0]),
        .out_data      (chain_data[0])
    );

    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        pft_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    pft_rotate #(
        .POS_WIDTH (POS_WIDTH)
    ) u_rotate (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chain_valid[N_CELLS]),
        .in_ready      (chain_ready[N_CELLS]),
        .in_data       (chain_data[N_CELLS]),
        .out_valid     (out_valid),
        .out_ready     (!out_stall),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_heading   (out_heading),
        .out_curvature (out_curvature),
        .out_station   (out_station)
    );

    // input backs up only behind a full pipeline held by the receiver
    `PFT_ASSERT_IMPLIES(a_stall_needs_full, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while output not held")
    `PFT_ASSERT_IMPLIES(a_chain_blocked, clk, rst_n, chain_valid[N_CELLS] && !chain_ready[N_CELLS], out_valid && out_stall, "CORDIC row blocked without a held result")
    // an open front stage that takes nothing stays open
    `PFT_ASSERT_NEXT(a_front_stays_open, clk, rst_n, !in_valid && !in_stall, !in_stall, "front stage closed with no new item")

endmodule

// ----- tb/sv/pft_tb_pkg.sv -----
// Action codes shared by the planar frame transform testbench files.
package pft_tb_pkg;

    localparam logic ACT_LOCAL_TO_GLOBAL = 1'b0;
    localparam logic ACT_GLOBAL_TO_LOCAL = 1'b1;

endpackage

// ----- tb/sv/pft_checker.sv -----
// Checker for the planar frame transform: predicts each pose result and compares outputs.
module pft_checker
    import pft_pkg::*;
    import pft_tb_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     action,
    input  logic signed [POS_W-1:0]  ref_x,
    input  logic signed [POS_W-1:0]  ref_y,
    input  logic signed [HEAD_W-1:0] ref_heading,
    input  logic signed [POS_W-1:0]  tgt_x,
    input  logic signed [POS_W-1:0]  tgt_y,
    input  logic signed [HEAD_W-1:0] tgt_heading,
    input  logic signed [POS_W-1:0]  tgt_curvature,
    input  logic signed [POS_W-1:0]  tgt_station,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [POS_W-1:0]  out_x,
    input  logic signed [POS_W-1:0]  out_y,
    input  logic signed [HEAD_W-1:0] out_heading,
    input  logic signed [POS_W-1:0]  out_curvature,
    input  logic signed [POS_W-1:0]  out_station,
    output int                       pending,
    output int                       fail_count,
    output int                       results_checked
);

    localparam longint TURN_Q30    = 64'sd6746518852;
    localparam longint HALF_Q30    = 64'sd3373259426;
    localparam longint QUARTER_Q30 = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam int     ATAN_DEPTH  = 32;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  curvature;
        logic signed [POS_W-1:0]  station;
    } pose_t;

    // atan(2^-i) in Q.30, truncated
    longint atan_tab [ATAN_DEPTH] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1, 0, 0
    };

    pose_t pose_q [$];
    pose_t want;
    int    mism;

    function automatic void heading_cos_sin(input logic signed [HEAD_W-1:0] hd,
                                            output longint co, output longint si);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(hd) * 16384;
        flip = 1'b0;
        // reduce to [-pi, pi], then fold into [-pi/2, pi/2] with a sign flip
        z = z - (z / TURN_Q30) * TURN_Q30;
        if (z > HALF_Q30)
            z = z - TURN_Q30;
        if (z < -HALF_Q30)
            z = z + TURN_Q30;
        if (z > QUARTER_Q30)
        begin
            z = z - HALF_Q30;
            flip = 1'b1;
        end
        else if (z < -QUARTER_Q30)
        begin
            z = z + HALF_Q30;
            flip = 1'b1;
        end
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_DEPTH; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            // zero residual rotates the positive way
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[i];
            end
        end
        co = flip ? -x : x;
        si = flip ? -y : y;
    endfunction

    // a * c / 2^30, rounded to nearest with halves away from zero
    function automatic longint round_q30(input longint a, input longint c);
        logic [95:0] ua;
        logic [95:0] uc;
        logic [95:0] prod;
        longint      mag;
        ua = (a < 0) ? 96'(-a) : 96'(a);
        uc = (c < 0) ? 96'(-c) : 96'(c);
        prod = ua * uc;
        prod = (prod + (96'd1 << 29)) >> 30;
        mag = longint'(prod[63:0]);
        return ((a < 0) != (c < 0)) ? -mag : mag;
    endfunction

    function automatic longint sat_signed(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic pose_t transform_pose(
        input logic                     act,
        input logic signed [POS_W-1:0]  rx,
        input logic signed [POS_W-1:0]  ry,
        input logic signed [HEAD_W-1:0] rh,
        input logic signed [POS_W-1:0]  tx,
        input logic signed [POS_W-1:0]  ty,
        input logic signed [HEAD_W-1:0] th,
        input logic signed [POS_W-1:0]  curv,
        input logic signed [POS_W-1:0]  stn
    );
        longint co;
        longint si;
        longint ox;
        longint oy;
        longint oh;
        longint dx;
        longint dy;
        pose_t  p;
        heading_cos_sin(rh, co, si);
        if (act == ACT_LOCAL_TO_GLOBAL)
        begin
            ox = round_q30(tx, co) - round_q30(ty, si) + longint'(rx);
            oy = round_q30(tx, si) + round_q30(ty, co) + longint'(ry);
            oh = longint'(rh) + longint'(th);
            p.station = stn;
        end
        else
        begin
            dx = longint'(tx) - longint'(rx);
            dy = longint'(ty) - longint'(ry);
            ox = round_q30(dx, co) + round_q30(dy, si);
            oy = round_q30(dy, co) - round_q30(dx, si);
            oh = longint'(th) - longint'(rh);
            p.station = '0;
        end
        p.x = 32'(sat_signed(ox, POS_WIDTH));
        p.y = 32'(sat_signed(oy, POS_WIDTH));
        p.heading = 24'(sat_signed(oh, HEAD_W));
        p.curvature = curv;
        return p;
    endfunction

    function automatic int field_diff(input string name, input longint exp_v,
                                      input longint got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_q.delete();
            pending <= 0;
            fail_count <= 0;
            results_checked <= 0;
        end
        else
        begin
            mism = 0;
            // retire before queueing: a result never belongs to an item of the same cycle
            if (out_valid && !out_stall)
            begin
                if (pose_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got x=%0d y=%0d",
                             $time, out_x, out_y);
                    mism = 1;
                end
                else
                begin
                    want = pose_q.pop_front();
                    mism = field_diff("out_x", want.x, out_x)
                         + field_diff("out_y", want.y, out_y)
                         + field_diff("out_heading", want.heading, out_heading)
                         + field_diff("out_curvature", want.curvature, out_curvature)
                         + field_diff("out_station", want.station, out_station);
                    results_checked <= results_checked + 1;
                end
            end
            if (in_valid && !in_stall)
                pose_q.push_back(transform_pose(action, ref_x, ref_y, ref_heading,
                                                tgt_x, tgt_y, tgt_heading,
                                                tgt_curvature, tgt_station));
            pending <= pose_q.size();
            fail_count <= fail_count + mism;
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the planar frame transform: clock, reset, stimulus and verdict.
module tb_top;
    import pft_pkg::*;
    import pft_tb_pkg::*;

    localparam int LATENCY      = CORDIC_STAGES_DEF + 9;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 150;

    localparam logic signed [POS_W-1:0]  PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0]  PMIN = 32'sh8000_0000;
    localparam logic signed [HEAD_W-1:0] HMAX = 24'sh7F_FFFF;
    localparam logic signed [HEAD_W-1:0] HMIN = 24'sh80_0000;
    localparam int QUARTER_Q16 = 102944;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     out_stall = 1'b0;
    logic                     action = 1'b0;
    logic signed [POS_W-1:0]  ref_x = '0;
    logic signed [POS_W-1:0]  ref_y = '0;
    logic signed [HEAD_W-1:0] ref_heading = '0;
    logic signed [POS_W-1:0]  tgt_x = '0;
    logic signed [POS_W-1:0]  tgt_y = '0;
    logic signed [HEAD_W-1:0] tgt_heading = '0;
    logic signed [POS_W-1:0]  tgt_curvature = '0;
    logic signed [POS_W-1:0]  tgt_station = '0;

    logic                     in_stall;
    logic                     out_valid;
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [HEAD_W-1:0] out_heading;
    logic signed [POS_W-1:0]  out_curvature;
    logic signed [POS_W-1:0]  out_station;

    int pending;
    int fail_count;
    int results_checked;
    int send_idle_pct = 31;
    int recv_stall_pct = 66;
    int n_l2g = 0;
    int n_g2l = 0;

    planar_frame_transform dut (.*);

    pft_checker u_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);

    task automatic send_pose(
        input logic                     act,
        input logic signed [POS_W-1:0]  rx,
        input logic signed [POS_W-1:0]  ry,
        input logic signed [HEAD_W-1:0] rh,
        input logic signed [POS_W-1:0]  tx,
        input logic signed [POS_W-1:0]  ty,
        input logic signed [HEAD_W-1:0] th,
        input logic signed [POS_W-1:0]  curv,
        input logic signed [POS_W-1:0]  stn
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        ref_x <= rx;
        ref_y <= ry;
        ref_heading <= rh;
        tgt_x <= tx;
        tgt_y <= ty;
        tgt_heading <= th;
        tgt_curvature <= curv;
        tgt_station <= stn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (act == ACT_LOCAL_TO_GLOBAL)
            n_l2g++;
        else
            n_g2l++;
    endtask

    function automatic logic signed [POS_W-1:0] near_pos();
        return 32'(int'($urandom_range(2097151)) - 1048576);
    endfunction

    task automatic send_random();
        logic                     act;
        logic signed [HEAD_W-1:0] rh;
        logic signed [HEAD_W-1:0] th;
        int                       kind;
        int                       k;
        act = ($urandom_range(1) == 0) ? ACT_LOCAL_TO_GLOBAL : ACT_GLOBAL_TO_LOCAL;
        kind = int'($urandom_range(3));
        if (kind == 0)
        begin
            // full range on every field
            send_pose(act, $urandom, $urandom, 24'($urandom), $urandom, $urandom,
                      24'($urandom), $urandom, $urandom);
        end
        else if (kind == 3)
        begin
            // hug the quadrant fold points
            k = int'($urandom_range(16)) - 8;
            rh = 24'(k * QUARTER_Q16 + int'($urandom_range(6)) - 3);
            th = 24'(int'($urandom_range(1647100)) - 823550);
            send_pose(act, near_pos(), near_pos(), rh, near_pos(), near_pos(), th,
                      $urandom, $urandom);
        end
        else
        begin
            // positions and headings in a working range, no saturation
            rh = 24'(int'($urandom_range(1647100)) - 823550);
            th = 24'(int'($urandom_range(1647100)) - 823550);
            send_pose(act, near_pos(), near_pos(), rh, near_pos(), near_pos(), th,
                      $urandom, $urandom);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int fold_hd [8] = '{102943, 102944, -102943, -102944, 205887, 205888,
                            -205888, 411775};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zeros, field extremes, saturation both ways, angle folds, rounding
        send_pose(ACT_LOCAL_TO_GLOBAL, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(ACT_GLOBAL_TO_LOCAL, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(ACT_LOCAL_TO_GLOBAL, PMAX, PMIN, 0, PMAX, PMIN, 0, PMAX, PMIN);
        send_pose(ACT_LOCAL_TO_GLOBAL, PMIN, PMAX, 0, PMIN, PMAX, 0, PMIN, PMAX);
        send_pose(ACT_GLOBAL_TO_LOCAL, PMIN, PMAX, 0, PMAX, PMIN, 0, PMAX, PMAX);
        send_pose(ACT_GLOBAL_TO_LOCAL, PMAX, PMIN, 0, PMIN, PMAX, 0, PMIN, PMIN);
        send_pose(ACT_LOCAL_TO_GLOBAL, 1000, -1000, HMAX, 2000, 3000, HMAX, 5, -5);
        send_pose(ACT_LOCAL_TO_GLOBAL, 1000, -1000, HMIN, 2000, 3000, HMIN, -5, 5);
        send_pose(ACT_GLOBAL_TO_LOCAL, PMAX, PMAX, HMIN, PMIN, PMIN, HMAX, 1, 1);
        send_pose(ACT_GLOBAL_TO_LOCAL, PMIN, PMIN, HMAX, PMAX, PMAX, HMIN, -1, -1);
        foreach (fold_hd[i])
            send_pose((i % 2 == 0) ? ACT_LOCAL_TO_GLOBAL : ACT_GLOBAL_TO_LOCAL,
                      12345, -54321, 24'(fold_hd[i]), 1000000, -700000,
                      24'(-fold_hd[i]), 32'(i), 32'(-i));
        send_pose(ACT_LOCAL_TO_GLOBAL, 0, 0, 0, 1, -1, 1, 0, 7);
        send_pose(ACT_GLOBAL_TO_LOCAL, 0, 0, 51472, -1, 1, -1, 0, 7);
        send_pose(ACT_LOCAL_TO_GLOBAL, -1, -1, -1, 3, -3, 0, 0, 0);
        send_pose(ACT_GLOBAL_TO_LOCAL, 512, -512, -51472, -512, 512, 0, 0, 0);

        repeat (PHASE_ITEMS) send_random();

        // hold off until the pipeline has emptied
        in_valid <= 1'b0;
        wait_drained();

        send_idle_pct <= 66;
        recv_stall_pct <= 31;
        repeat (PHASE_ITEMS) send_random();

        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        repeat (PHASE_ITEMS) send_random();

        in_valid <= 1'b0;
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);

        $display("Run covered %0d local-to-global and %0d global-to-local items, %0d checked.",
                 n_l2g, n_g2l, results_checked);
        $display("Included field extremes, saturation, quadrant folds and three idle mixes.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("TB_ERROR");
        $finish;
    end

endmodule
